FILE: rtl/assert_macros.svh
// assertion helpers included by sd_card_init_sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// checked outside reset only
`define ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

FILE: rtl/sdi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdi_pkg
// Types and constants shared by the sd card init sequencer modules.
// ----------------------------------------------------------------------------
package sdi_pkg;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_CMD0   = 4'd1,
    PH_CMD8   = 4'd2,
    PH_APP55  = 4'd3,
    PH_ACMD41 = 4'd4,
    PH_CMD2   = 4'd5,
    PH_CMD3   = 4'd6,
    PH_CMD9   = 4'd7,
    PH_CMD7   = 4'd8,
    PH_CMD16  = 4'd9,
    PH_BUS55  = 4'd10,
    PH_ACMD6  = 4'd11
  } phase_t;

  typedef enum logic [1:0] {
    CFG_IDLE_LIMIT  = 2'd0,
    CFG_READY_LIMIT = 2'd1
  } cfg_reg_t;

  localparam logic [0:0] CMD_START    = 1'b0;

  localparam logic [5:0] SD_CMD0      = 6'd0;
  localparam logic [5:0] SD_CMD2      = 6'd2;
  localparam logic [5:0] SD_CMD3      = 6'd3;
  localparam logic [5:0] SD_ACMD6     = 6'd6;
  localparam logic [5:0] SD_CMD7      = 6'd7;
  localparam logic [5:0] SD_CMD8      = 6'd8;
  localparam logic [5:0] SD_CMD9      = 6'd9;
  localparam logic [5:0] SD_CMD16     = 6'd16;
  localparam logic [5:0] SD_ACMD41    = 6'd41;
  localparam logic [5:0] SD_CMD55     = 6'd55;

  localparam logic [31:0] CMD8_ARG     = 32'h0000_01AA;
  localparam logic [7:0]  CHECK_PATTERN = 8'hAA;
  localparam logic [31:0] OCR_HCS_ARG  = 32'h40FF_8000;
  localparam logic [31:0] OCR_SDSC_ARG = 32'h00FF_8000;
  localparam logic [31:0] BLOCK_LEN    = 32'd512;
  localparam logic [31:0] BUS_WIDTH_4  = 32'd2;

  localparam logic [9:0]  IDLE_LIMIT_RESET  = 10'd200;
  localparam logic [11:0] READY_LIMIT_RESET = 12'd1300;

  typedef struct packed {
    logic        cmd;
    logic [31:0] resp_word0;
    logic [31:0] resp_word1;
    logic [31:0] resp_word2;
    logic [31:0] resp_word3;
    logic        card_present;
  } item_t;

  typedef struct packed {
    logic        issue_command;
    logic [5:0]  command_index;
    logic        send_init_clocks;
    logic        response_expected;
    logic        long_response;
    logic        check_crc;
    logic [31:0] argument;
    logic        finished;
    logic        succeeded;
    logic [31:0] capacity_sectors;
    logic        block_addressed;
  } result_t;

  typedef struct packed {
    logic [9:0]  idle_limit;
    logic [11:0] ready_limit;
  } limits_t;

endpackage

FILE: rtl/sd_card_init_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sd_card_init_sequencer
// SD card bring-up sequencer: start and response transfers in, commands out.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one transfer per event: tuser 0 starts the sequence, tuser 1
//   reports the response of the command last issued (short response in
//   word 0, a long response in words 0 to 3) together with card presence.
//   m_axis returns at most one transfer per input: tuser 1 names the next
//   command to send, tuser 0 reports the end of the sequence with the
//   outcome, capacity in sectors and addressing mode. A response that
//   arrives while the sequence is idle produces no output transfer.
//   cfg writes the retry limits (index 0 idle retries, index 1 ready polls);
//   write them only while no transfer is in flight.
// Timing:
//   an input transfer is held in the input register and stepped into the
//   result register, from which its output is presented. One transfer per
//   cycle is accepted while m_axis does not stall; the step logic between
//   the two registers is combinational.
// Reset clears the sequence to idle, empties both registers and restores
// the limits to 200 and 1300. When m_axis stalls, the result register holds
// and the input register takes one more transfer before s_axis_tready drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sd_card_init_sequencer (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] resp_word0, [63:32] resp_word1, [95:64] resp_word2,
  // [127:96] resp_word3, [128] card_present, [135:129] zero
  input  logic [135:0] s_axis_tdata,
  // [0] cmd
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [5:0] command_index, [6] send_init_clocks, [7] response_expected,
  // [8] long_response, [9] check_crc, [41:10] argument, [42] finished,
  // [43] succeeded, [75:44] capacity_sectors, [76] block_addressed, [79:77] zero
  output logic [79:0]  m_axis_tdata,
  // [0] issue_command
  output logic         m_axis_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [11:0]  cfg_data
);

  logic              in_valid;
  sdi_pkg::item_t    in_item;
  logic              out_valid;
  sdi_pkg::result_t  out_res;
  sdi_pkg::limits_t  limits;
  sdi_pkg::result_t  step_res;
  logic              step_has_result;
  logic              advance;
  logic              fire;
  logic              s_xfer;
  logic              end_fail;
  logic              out_stall;

  assign advance       = !out_valid || m_axis_tready;
  assign fire          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.idle_limit  <= sdi_pkg::IDLE_LIMIT_RESET;
      limits.ready_limit <= sdi_pkg::READY_LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sdi_pkg::CFG_IDLE_LIMIT:  limits.idle_limit  <= cfg_data[9:0];
        sdi_pkg::CFG_READY_LIMIT: limits.ready_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_xfer) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      in_item.cmd          <= s_axis_tuser;
      in_item.resp_word0   <= s_axis_tdata[31:0];
      in_item.resp_word1   <= s_axis_tdata[63:32];
      in_item.resp_word2   <= s_axis_tdata[95:64];
      in_item.resp_word3   <= s_axis_tdata[127:96];
      in_item.card_present <= s_axis_tdata[128];
    end
  end

  sdi_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .item       (in_item),
    .limits     (limits),
    .result     (step_res),
    .has_result (step_has_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire && step_has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= step_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.issue_command;
  assign m_axis_tdata  = {3'd0, out_res.block_addressed, out_res.capacity_sectors,
                          out_res.succeeded, out_res.finished, out_res.argument,
                          out_res.check_crc, out_res.long_response,
                          out_res.response_expected, out_res.send_init_clocks,
                          out_res.command_index};

  assign end_fail  = m_axis_tvalid && m_axis_tdata[42] && !m_axis_tdata[43];
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // every output is either a command or an end report
  `ASSERT_ALWAYS(a_cmd_or_end, m_axis_tvalid |-> (m_axis_tuser ^ m_axis_tdata[42]), "bad kind")

  // a failed sequence reports no capacity
  `ASSERT_ALWAYS(a_fail_no_cap, end_fail |-> (m_axis_tdata[76:44] == 33'd0), "capacity on fail")

  // input side only stalls behind a full, blocked pipe
  `ASSERT_RUN(a_stall_cause, !s_axis_tready |-> (in_valid && out_stall), "stall without cause")

endmodule

FILE: rtl/sdi_csd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdi_csd
// Decodes the card capacity in 512-byte sectors from a CSD register (v1/v2).
// ----------------------------------------------------------------------------
module sdi_csd (
  input  logic [31:0] resp_word1,
  input  logic [31:0] resp_word2,
  input  logic [31:0] resp_word3,
  output logic [31:0] sectors
);

  logic [21:0] v2_size;
  logic [22:0] v2_plus;
  logic [11:0] v1_size;
  logic [12:0] v1_plus;
  logic [3:0]  v1_mult;
  logic [3:0]  v1_bl;
  logic [3:0]  v1_bl_adj;
  logic [4:0]  v1_shift;
  logic [31:0] v2_sectors;
  logic [31:0] v1_sectors;

  always_comb begin
    v2_size = {resp_word2[5:0], resp_word1[31:16]};
    v2_plus = {1'b0, v2_size} + 23'd1;
    // size + 1 reaching 2^22 means 2^32 sectors, saturate
    if (v2_plus[22]) begin
      v2_sectors = 32'hFFFF_FFFF;
    end else begin
      v2_sectors = {v2_plus[21:0], 10'd0};
    end

    v1_size   = {resp_word2[9:0], resp_word1[31:30]};
    v1_plus   = {1'b0, v1_size} + 13'd1;
    v1_mult   = {1'b0, resp_word1[17:15]} + 4'd2;
    v1_bl     = resp_word2[19:16];
    // short block length codes count as 512 bytes
    v1_bl_adj = (v1_bl < 4'd9) ? 4'd0 : (v1_bl - 4'd9);
    v1_shift  = {1'b0, v1_mult} + {1'b0, v1_bl_adj};
    v1_sectors = {19'd0, v1_plus} << v1_shift;

    sectors = resp_word3[30] ? v2_sectors : v1_sectors;
  end

endmodule

FILE: rtl/sdi_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdi_seq
// Init sequence state and the per-response step that picks the next command.
// ----------------------------------------------------------------------------
module sdi_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  sdi_pkg::item_t      item,
  input  sdi_pkg::limits_t    limits,
  output sdi_pkg::result_t    result,
  output logic                has_result
);

  sdi_pkg::phase_t phase;
  sdi_pkg::phase_t phase_next;
  logic [11:0]     retry_count;
  logic [11:0]     retry_count_next;
  logic            host_capacity_flag;
  logic            host_capacity_flag_next;
  logic [15:0]     relative_address;
  logic [15:0]     relative_address_next;
  logic            high_capacity;
  logic            high_capacity_next;
  logic [31:0]     capacity;
  logic [31:0]     capacity_next;

  logic [11:0] retry_inc;
  logic        echo_ok;
  logic        idle_retry_left;
  logic        ready_timeout;
  logic        card_ready;
  logic [31:0] rca_arg;
  logic [31:0] new_rca_arg;
  logic [31:0] csd_sectors;

  function automatic sdi_pkg::result_t issue(input logic [5:0] index, input logic resp,
                                             input logic lng, input logic crc,
                                             input logic [31:0] arg, input logic init);
    sdi_pkg::result_t r;
    r = '0;
    r.issue_command     = 1'b1;
    r.command_index     = index;
    r.send_init_clocks  = init;
    r.response_expected = resp;
    r.long_response     = lng;
    r.check_crc         = crc;
    r.argument          = arg;
    return r;
  endfunction

  sdi_csd u_csd (
    .resp_word1 (item.resp_word1),
    .resp_word2 (item.resp_word2),
    .resp_word3 (item.resp_word3),
    .sectors    (csd_sectors)
  );

  assign retry_inc       = retry_count + 12'd1;
  assign echo_ok         = (item.resp_word0[7:0] == sdi_pkg::CHECK_PATTERN);
  assign idle_retry_left = (retry_inc < {2'd0, limits.idle_limit});
  assign ready_timeout   = (retry_inc >= limits.ready_limit);
  assign card_ready      = item.resp_word0[31];
  assign rca_arg         = {relative_address, 16'd0};
  assign new_rca_arg     = {item.resp_word0[31:16], 16'd0};

  // next state
  always_comb begin
    phase_next              = phase;
    retry_count_next        = retry_count;
    host_capacity_flag_next = host_capacity_flag;
    relative_address_next   = relative_address;
    high_capacity_next      = high_capacity;
    capacity_next           = capacity;
    if (item.cmd == sdi_pkg::CMD_START) begin
      retry_count_next        = '0;
      host_capacity_flag_next = 1'b0;
      relative_address_next   = '0;
      high_capacity_next      = 1'b0;
      capacity_next           = '0;
      phase_next = item.card_present ? sdi_pkg::PH_CMD0 : sdi_pkg::PH_IDLE;
    end else if (phase == sdi_pkg::PH_IDLE) begin
      phase_next = sdi_pkg::PH_IDLE;
    end else if (!item.card_present) begin
      capacity_next = '0;
      phase_next    = sdi_pkg::PH_IDLE;
    end else begin
      unique case (phase)
        sdi_pkg::PH_CMD0:  phase_next = sdi_pkg::PH_CMD8;
        sdi_pkg::PH_CMD8: begin
          if (echo_ok) begin
            host_capacity_flag_next = 1'b1;
            retry_count_next        = '0;
            phase_next              = sdi_pkg::PH_APP55;
          end else if (idle_retry_left) begin
            retry_count_next = retry_inc;
            phase_next       = sdi_pkg::PH_CMD0;
          end else begin
            host_capacity_flag_next = 1'b0;
            retry_count_next        = '0;
            phase_next              = sdi_pkg::PH_APP55;
          end
        end
        sdi_pkg::PH_APP55: phase_next = sdi_pkg::PH_ACMD41;
        sdi_pkg::PH_ACMD41: begin
          retry_count_next = retry_inc;
          if (ready_timeout) begin
            capacity_next = '0;
            phase_next    = sdi_pkg::PH_IDLE;
          end else if (card_ready) begin
            high_capacity_next = item.resp_word0[30] & host_capacity_flag;
            phase_next         = sdi_pkg::PH_CMD2;
          end else begin
            phase_next = sdi_pkg::PH_APP55;
          end
        end
        sdi_pkg::PH_CMD2:  phase_next = sdi_pkg::PH_CMD3;
        sdi_pkg::PH_CMD3: begin
          relative_address_next = item.resp_word0[31:16];
          phase_next            = sdi_pkg::PH_CMD9;
        end
        sdi_pkg::PH_CMD9: begin
          capacity_next = csd_sectors;
          phase_next    = sdi_pkg::PH_CMD7;
        end
        sdi_pkg::PH_CMD7:  phase_next = sdi_pkg::PH_CMD16;
        sdi_pkg::PH_CMD16: phase_next = sdi_pkg::PH_BUS55;
        sdi_pkg::PH_BUS55: phase_next = sdi_pkg::PH_ACMD6;
        sdi_pkg::PH_ACMD6: phase_next = sdi_pkg::PH_IDLE;
        default:           phase_next = sdi_pkg::PH_IDLE;
      endcase
    end
  end

  // result for the current response
  always_comb begin
    result     = '0;
    has_result = 1'b1;
    if (item.cmd == sdi_pkg::CMD_START) begin
      if (item.card_present) begin
        result = issue(sdi_pkg::SD_CMD0, 1'b0, 1'b0, 1'b0, '0, 1'b1);
      end else begin
        result.finished = 1'b1;
      end
    end else if (phase == sdi_pkg::PH_IDLE) begin
      has_result = 1'b0;
    end else if (!item.card_present) begin
      result.finished = 1'b1;
    end else begin
      unique case (phase)
        sdi_pkg::PH_CMD0:
          result = issue(sdi_pkg::SD_CMD8, 1'b1, 1'b0, 1'b1, sdi_pkg::CMD8_ARG, 1'b0);
        sdi_pkg::PH_CMD8: begin
          if (!echo_ok && idle_retry_left) begin
            result = issue(sdi_pkg::SD_CMD0, 1'b0, 1'b0, 1'b0, '0, 1'b1);
          end else begin
            result = issue(sdi_pkg::SD_CMD55, 1'b1, 1'b0, 1'b1, rca_arg, 1'b0);
          end
        end
        sdi_pkg::PH_APP55:
          result = issue(sdi_pkg::SD_ACMD41, 1'b1, 1'b0, 1'b0,
                         host_capacity_flag ? sdi_pkg::OCR_HCS_ARG : sdi_pkg::OCR_SDSC_ARG,
                         1'b0);
        sdi_pkg::PH_ACMD41: begin
          if (ready_timeout) begin
            result.finished = 1'b1;
          end else if (card_ready) begin
            result = issue(sdi_pkg::SD_CMD2, 1'b1, 1'b1, 1'b1, '0, 1'b0);
          end else begin
            result = issue(sdi_pkg::SD_CMD55, 1'b1, 1'b0, 1'b1, rca_arg, 1'b0);
          end
        end
        sdi_pkg::PH_CMD2:
          result = issue(sdi_pkg::SD_CMD3, 1'b1, 1'b0, 1'b1, '0, 1'b0);
        sdi_pkg::PH_CMD3:
          result = issue(sdi_pkg::SD_CMD9, 1'b1, 1'b1, 1'b1, new_rca_arg, 1'b0);
        sdi_pkg::PH_CMD9:
          result = issue(sdi_pkg::SD_CMD7, 1'b1, 1'b0, 1'b1, rca_arg, 1'b0);
        sdi_pkg::PH_CMD7:
          result = issue(sdi_pkg::SD_CMD16, 1'b1, 1'b0, 1'b1, sdi_pkg::BLOCK_LEN, 1'b0);
        sdi_pkg::PH_CMD16:
          result = issue(sdi_pkg::SD_CMD55, 1'b1, 1'b0, 1'b1, rca_arg, 1'b0);
        sdi_pkg::PH_BUS55:
          result = issue(sdi_pkg::SD_ACMD6, 1'b1, 1'b0, 1'b1, sdi_pkg::BUS_WIDTH_4, 1'b0);
        sdi_pkg::PH_ACMD6: begin
          result.finished         = 1'b1;
          result.succeeded        = 1'b1;
          result.capacity_sectors = capacity;
          result.block_addressed  = high_capacity;
        end
        default: has_result = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= sdi_pkg::PH_IDLE;
      retry_count        <= '0;
      host_capacity_flag <= 1'b0;
      relative_address   <= '0;
      high_capacity      <= 1'b0;
      capacity           <= '0;
    end else if (fire) begin
      phase              <= phase_next;
      retry_count        <= retry_count_next;
      host_capacity_flag <= host_capacity_flag_next;
      relative_address   <= relative_address_next;
      high_capacity      <= high_capacity_next;
      capacity           <= capacity_next;
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sd card init sequencer. Start and response
// transfers (mostly complete bring-up runs with random response content,
// some cut short by removal or restart, plus random noise) are driven with
// random gaps while the output side stalls at random. Every output transfer
// is compared field by field against an in-bench model of the command
// sequence. The retry limits are swept between batches, extremes included.
// ----------------------------------------------------------------------------
module tb;

  localparam logic       CMD_RESPONSE = 1'b1;
  localparam logic [1:0] CFG_SPARE_A  = 2'd2;
  localparam logic [1:0] CFG_SPARE_B  = 2'd3;

  typedef struct {
    sdi_pkg::item_t it;
    bit             drain;  // hold off until every awaited output has arrived
  } stim_t;

  logic         clk;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [79:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [11:0]  cfg_data = '0;

  sd_card_init_sequencer dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // sequence model state
  sdi_pkg::phase_t ph = sdi_pkg::PH_IDLE;
  logic [11:0] tries = '0;
  logic        hcs_flag = 1'b0;
  logic [15:0] card_rca = '0;
  logic        hc_card = 1'b0;
  logic [31:0] cap_sectors = '0;
  logic [9:0]  lim_idle = sdi_pkg::IDLE_LIMIT_RESET;
  logic [11:0] lim_ready = sdi_pkg::READY_LIMIT_RESET;

  stim_t            send_q[$];
  sdi_pkg::result_t awaited_out[$];
  stim_t            cur;
  sdi_pkg::item_t   acc_item;
  sdi_pkg::result_t want, got;

  bit in_busy = 1'b0;
  bit in_gaps = 1'b1;
  bit out_gaps = 1'b1;
  int gap_left = 0;
  int stall_left = 0;

  int n_err = 0;
  int n_queued = 0;
  int n_in = 0;
  int n_ignored = 0;
  int n_out = 0;
  int n_good = 0;
  int n_bad = 0;
  int n_cfg = 0;

  // session planning
  int sess_len;
  int cut_at;
  int cut_kind;
  bit cut_done;

  function automatic sdi_pkg::result_t next_cmd(logic [5:0] idx, logic rsp, logic lng,
                                                logic crc, logic [31:0] arg, logic init,
                                                sdi_pkg::phase_t nxt);
    sdi_pkg::result_t o;
    o = '0;
    o.issue_command = 1'b1;
    o.command_index = idx;
    o.send_init_clocks = init;
    o.response_expected = rsp;
    o.long_response = lng;
    o.check_crc = crc;
    o.argument = arg;
    ph = nxt;
    return o;
  endfunction

  function automatic sdi_pkg::result_t seq_end(logic ok);
    sdi_pkg::result_t o;
    o = '0;
    o.finished = 1'b1;
    if (ok) begin
      o.succeeded = 1'b1;
      o.capacity_sectors = cap_sectors;
      o.block_addressed = hc_card;
    end else begin
      cap_sectors = '0;
    end
    ph = sdi_pkg::PH_IDLE;
    return o;
  endfunction

  // card size in 512-byte sectors from the csd words
  function automatic logic [31:0] csd_sectors(logic [31:0] w1, w2, w3);
    logic [63:0] n;
    logic [31:0] c_size;
    int unsigned mult, bl;
    if (w3[30]) begin
      n = ({42'b0, w2[5:0], w1[31:16]} + 64'd1) << 10;
      return (n > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : n[31:0];
    end
    c_size = {20'b0, w2[9:0], w1[31:30]};
    mult = {29'b0, w1[17:15]} + 32'd2;
    bl = {28'b0, w2[19:16]};
    if (bl < 9) bl = 9;
    return ((c_size + 32'd1) << mult) << (bl - 9);
  endfunction

  function automatic bit bringup_step(input sdi_pkg::item_t it, output sdi_pkg::result_t r);
    logic [31:0] rca_arg;
    rca_arg = {card_rca, 16'h0};
    r = '0;
    if (it.cmd == sdi_pkg::CMD_START) begin
      tries = '0;
      hcs_flag = 1'b0;
      card_rca = '0;
      hc_card = 1'b0;
      cap_sectors = '0;
      if (!it.card_present) r = seq_end(1'b0);
      else r = next_cmd(sdi_pkg::SD_CMD0, 1'b0, 1'b0, 1'b0, '0, 1'b1, sdi_pkg::PH_CMD0);
      return 1'b1;
    end
    if (ph == sdi_pkg::PH_IDLE) return 1'b0;
    if (!it.card_present) begin
      r = seq_end(1'b0);
      return 1'b1;
    end
    case (ph)
      sdi_pkg::PH_CMD0:
        r = next_cmd(sdi_pkg::SD_CMD8, 1'b1, 1'b0, 1'b1, sdi_pkg::CMD8_ARG, 1'b0,
                     sdi_pkg::PH_CMD8);
      sdi_pkg::PH_CMD8: begin
        tries = tries + 12'd1;
        if (it.resp_word0[7:0] == sdi_pkg::CHECK_PATTERN) begin
          hcs_flag = 1'b1;
        end else if (tries < {2'b0, lim_idle}) begin
          r = next_cmd(sdi_pkg::SD_CMD0, 1'b0, 1'b0, 1'b0, '0, 1'b1, sdi_pkg::PH_CMD0);
          return 1'b1;
        end else begin
          hcs_flag = 1'b0;
        end
        tries = '0;
        r = next_cmd(sdi_pkg::SD_CMD55, 1'b1, 1'b0, 1'b1, rca_arg, 1'b0, sdi_pkg::PH_APP55);
      end
      sdi_pkg::PH_APP55:
        r = next_cmd(sdi_pkg::SD_ACMD41, 1'b1, 1'b0, 1'b0,
                     hcs_flag ? sdi_pkg::OCR_HCS_ARG : sdi_pkg::OCR_SDSC_ARG, 1'b0,
                     sdi_pkg::PH_ACMD41);
      sdi_pkg::PH_ACMD41: begin
        // poll count is tested before the ready bit
        tries = tries + 12'd1;
        if (tries >= lim_ready) begin
          r = seq_end(1'b0);
        end else if (it.resp_word0[31]) begin
          hc_card = it.resp_word0[30] & hcs_flag;
          r = next_cmd(sdi_pkg::SD_CMD2, 1'b1, 1'b1, 1'b1, '0, 1'b0, sdi_pkg::PH_CMD2);
        end else begin
          r = next_cmd(sdi_pkg::SD_CMD55, 1'b1, 1'b0, 1'b1, rca_arg, 1'b0,
                       sdi_pkg::PH_APP55);
        end
      end
      sdi_pkg::PH_CMD2:
        r = next_cmd(sdi_pkg::SD_CMD3, 1'b1, 1'b0, 1'b1, '0, 1'b0, sdi_pkg::PH_CMD3);
      sdi_pkg::PH_CMD3: begin
        card_rca = it.resp_word0[31:16];
        r = next_cmd(sdi_pkg::SD_CMD9, 1'b1, 1'b1, 1'b1, {card_rca, 16'h0}, 1'b0,
                     sdi_pkg::PH_CMD9);
      end
      sdi_pkg::PH_CMD9: begin
        cap_sectors = csd_sectors(it.resp_word1, it.resp_word2, it.resp_word3);
        r = next_cmd(sdi_pkg::SD_CMD7, 1'b1, 1'b0, 1'b1, rca_arg, 1'b0, sdi_pkg::PH_CMD7);
      end
      sdi_pkg::PH_CMD7:
        r = next_cmd(sdi_pkg::SD_CMD16, 1'b1, 1'b0, 1'b1, sdi_pkg::BLOCK_LEN, 1'b0,
                     sdi_pkg::PH_CMD16);
      sdi_pkg::PH_CMD16:
        r = next_cmd(sdi_pkg::SD_CMD55, 1'b1, 1'b0, 1'b1, rca_arg, 1'b0, sdi_pkg::PH_BUS55);
      sdi_pkg::PH_BUS55:
        r = next_cmd(sdi_pkg::SD_ACMD6, 1'b1, 1'b0, 1'b1, sdi_pkg::BUS_WIDTH_4, 1'b0,
                     sdi_pkg::PH_ACMD6);
      sdi_pkg::PH_ACMD6: r = seq_end(1'b1);
      default: begin
        ph = sdi_pkg::PH_IDLE;
        return 1'b0;
      end
    endcase
    return 1'b1;
  endfunction

  task automatic report(string msg);
    n_err++;
    if (n_err <= 25) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [31:0] g, logic [31:0] w);
    if (g !== w) report($sformatf("output %0d %s: got %0h, expected %0h", n_out, name, g, w));
  endtask

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] word();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  function automatic void put(logic cmd, logic [31:0] w0, w1, w2, w3, logic present,
                              bit drain);
    stim_t e;
    e.it.cmd = cmd;
    e.it.resp_word0 = w0;
    e.it.resp_word1 = w1;
    e.it.resp_word2 = w2;
    e.it.resp_word3 = w3;
    e.it.card_present = present;
    e.drain = drain;
    send_q.push_back(e);
    n_queued++;
  endfunction

  // response within a planned run; at the cut point the run is broken off
  function automatic void sess_rsp(logic [31:0] w0, w1, w2, w3);
    if (cut_done) return;
    if (sess_len == cut_at) begin
      cut_done = 1'b1;
      case (cut_kind)
        0: put(CMD_RESPONSE, w0, w1, w2, w3, 1'b0, 1'b0);
        1: put(sdi_pkg::CMD_START, w0, w1, w2, w3, 1'b1, 1'b0);
        default: put(sdi_pkg::CMD_START, w0, w1, w2, w3, 1'b0, 1'b0);
      endcase
    end else begin
      put(CMD_RESPONSE, w0, w1, w2, w3, 1'b1, 1'b0);
    end
    sess_len++;
  endfunction

  function automatic void queue_session(bit drain);
    int misses, polls;
    logic [31:0] w0, w1, w2, w3;
    sess_len = 0;
    cut_done = 1'b0;
    cut_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 20) : -1;
    cut_kind = $urandom_range(0, 2);
    misses = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
    polls = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 2);
    put(sdi_pkg::CMD_START, word(), word(), word(), word(), 1'b1, drain);
    sess_rsp(word(), word(), word(), word());
    repeat (misses) begin
      w0 = word();
      if (w0[7:0] == sdi_pkg::CHECK_PATTERN) w0[0] = ~w0[0];
      sess_rsp(w0, word(), word(), word());
      sess_rsp(word(), word(), word(), word());
    end
    w0 = word();
    if ($urandom_range(0, 7) != 0) w0[7:0] = sdi_pkg::CHECK_PATTERN;
    sess_rsp(w0, word(), word(), word());
    repeat (polls) begin
      sess_rsp(word(), word(), word(), word());
      w0 = word();
      w0[31] = 1'b0;
      sess_rsp(w0, word(), word(), word());
    end
    sess_rsp(word(), word(), word(), word());
    w0 = word();
    w0[31] = 1'b1;
    sess_rsp(w0, word(), word(), word());
    sess_rsp(word(), word(), word(), word());
    sess_rsp(word(), word(), word(), word());
    w1 = word();
    w2 = word();
    w3 = word();
    // largest v2 size, saturates the sector count
    if ($urandom_range(0, 7) == 0) begin
      w1[31:16] = 16'hFFFF;
      w2[5:0] = 6'h3F;
      w3[30] = 1'b1;
    end
    sess_rsp(word(), w1, w2, w3);
    repeat (4) sess_rsp(word(), word(), word(), word());
  endfunction

  function automatic void queue_noise();
    repeat ($urandom_range(1, 4))
      put(($urandom_range(0, 3) == 0) ? sdi_pkg::CMD_START : CMD_RESPONSE, word(), word(),
          word(), word(), $urandom_range(0, 5) != 0, 1'b0);
  endfunction

  task automatic settle();
    while (send_q.size() != 0 || in_busy || awaited_out.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(logic [1:0] idx, logic [11:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == sdi_pkg::CFG_IDLE_LIMIT) lim_idle = val[9:0];
    else if (idx == sdi_pkg::CFG_READY_LIMIT) lim_ready = val;
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("[%0t] timeout", $time);
    $display("FAILED: results differ");
    $finish;
  end

  // input side
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!in_busy) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (send_q.size() != 0 && !(send_q[0].drain && awaited_out.size() != 0)) begin
        cur = send_q.pop_front();
        s_axis_tdata <= {7'b0, cur.it.card_present, cur.it.resp_word3, cur.it.resp_word2,
                         cur.it.resp_word1, cur.it.resp_word0};
        s_axis_tuser <= cur.it.cmd;
        s_axis_tvalid <= 1'b1;
        in_busy = 1'b1;
        if (in_gaps) gap_left = gap_len();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output side backpressure
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (out_gaps) stall_left = gap_len();
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        acc_item.cmd = s_axis_tuser;
        acc_item.resp_word0 = s_axis_tdata[31:0];
        acc_item.resp_word1 = s_axis_tdata[63:32];
        acc_item.resp_word2 = s_axis_tdata[95:64];
        acc_item.resp_word3 = s_axis_tdata[127:96];
        acc_item.card_present = s_axis_tdata[128];
        if (bringup_step(acc_item, want)) awaited_out.push_back(want);
        else n_ignored++;
        n_in++;
        in_busy = 1'b0;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.issue_command = m_axis_tuser;
        got.command_index = m_axis_tdata[5:0];
        got.send_init_clocks = m_axis_tdata[6];
        got.response_expected = m_axis_tdata[7];
        got.long_response = m_axis_tdata[8];
        got.check_crc = m_axis_tdata[9];
        got.argument = m_axis_tdata[41:10];
        got.finished = m_axis_tdata[42];
        got.succeeded = m_axis_tdata[43];
        got.capacity_sectors = m_axis_tdata[75:44];
        got.block_addressed = m_axis_tdata[76];
        if (awaited_out.size() == 0) begin
          report($sformatf("output %0d arrived with nothing awaited", n_out));
        end else begin
          want = awaited_out.pop_front();
          check_field("issue_command", 32'(got.issue_command), 32'(want.issue_command));
          check_field("command_index", 32'(got.command_index), 32'(want.command_index));
          check_field("send_init_clocks", 32'(got.send_init_clocks),
                      32'(want.send_init_clocks));
          check_field("response_expected", 32'(got.response_expected),
                      32'(want.response_expected));
          check_field("long_response", 32'(got.long_response), 32'(want.long_response));
          check_field("check_crc", 32'(got.check_crc), 32'(want.check_crc));
          check_field("argument", got.argument, want.argument);
          check_field("finished", 32'(got.finished), 32'(want.finished));
          check_field("succeeded", 32'(got.succeeded), 32'(want.succeeded));
          check_field("capacity_sectors", got.capacity_sectors, want.capacity_sectors);
          check_field("block_addressed", 32'(got.block_addressed),
                      32'(want.block_addressed));
          if (want.finished && want.succeeded) n_good++;
          else if (want.finished) n_bad++;
        end
        n_out++;
      end
    end
  end

  initial begin
    int idle_set[7];
    int ready_set[7];
    int mark;
    idle_set = '{200, 1, 4095, 0, 3, 2, 0};
    ready_set = '{1300, 1, 4095, 0, 4, 7, 0};
    idle_set[6] = $urandom_range(1, 6) | ($urandom_range(0, 3) << 10);
    ready_set[6] = $urandom_range(2, 10);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: removal at start, response while idle, a full bring-up with one
    // missed echo, one busy poll, max rca and a saturating v2 csd, then a restart
    // while running and a removal mid-sequence
    put(sdi_pkg::CMD_START, '0, '0, '0, '0, 1'b0, 1'b0);
    put(CMD_RESPONSE, '1, '1, '1, '1, 1'b1, 1'b0);
    put(sdi_pkg::CMD_START, '1, '1, '1, '1, 1'b1, 1'b0);
    put(CMD_RESPONSE, '0, '0, '0, '0, 1'b1, 1'b0);
    put(CMD_RESPONSE, 32'h0000_0155, '0, '0, '0, 1'b1, 1'b0);
    put(CMD_RESPONSE, '0, '0, '0, '0, 1'b1, 1'b0);
    put(CMD_RESPONSE, sdi_pkg::CMD8_ARG, '0, '0, '0, 1'b1, 1'b0);
    put(CMD_RESPONSE, word(), word(), word(), word(), 1'b1, 1'b0);
    put(CMD_RESPONSE, sdi_pkg::OCR_SDSC_ARG, '0, '0, '0, 1'b1, 1'b0);
    put(CMD_RESPONSE, word(), word(), word(), word(), 1'b1, 1'b0);
    put(CMD_RESPONSE, 32'hC0FF_8000, '0, '0, '0, 1'b1, 1'b0);
    put(CMD_RESPONSE, word(), word(), word(), word(), 1'b1, 1'b0);
    put(CMD_RESPONSE, 32'hFFFF_0000, '0, '0, '0, 1'b1, 1'b0);
    put(CMD_RESPONSE, '0, 32'hFFFF_0000, 32'h0000_003F, 32'h4000_0000, 1'b1, 1'b0);
    put(CMD_RESPONSE, word(), word(), word(), word(), 1'b1, 1'b0);
    put(CMD_RESPONSE, word(), word(), word(), word(), 1'b1, 1'b0);
    put(CMD_RESPONSE, word(), word(), word(), word(), 1'b1, 1'b0);
    put(CMD_RESPONSE, word(), word(), word(), word(), 1'b1, 1'b0);
    put(sdi_pkg::CMD_START, '0, '0, '0, '0, 1'b1, 1'b1);
    put(CMD_RESPONSE, word(), word(), word(), word(), 1'b1, 1'b0);
    put(sdi_pkg::CMD_START, word(), word(), word(), word(), 1'b1, 1'b0);
    put(CMD_RESPONSE, word(), word(), word(), word(), 1'b0, 1'b0);

    for (int b = 0; b < 7; b++) begin
      settle();
      write_limit(sdi_pkg::CFG_IDLE_LIMIT, 12'(idle_set[b]));
      write_limit(sdi_pkg::CFG_READY_LIMIT, 12'(ready_set[b]));
      if (b == 0) begin
        write_limit(CFG_SPARE_A, 12'hFFF);
        write_limit(CFG_SPARE_B, 12'h000);
      end
      in_gaps = (b % 3) != 1;
      out_gaps = (b % 3) != 2;
      mark = n_queued;
      while (n_queued - mark < 270) begin
        if ($urandom_range(0, 4) == 0) queue_noise();
        else queue_session($urandom_range(0, 29) == 0);
      end
    end
    settle();

    if (awaited_out.size() != 0)
      report($sformatf("%0d outputs never arrived", awaited_out.size()));
    $display("run covered %0d input transfers (%0d ignored while idle), %0d output transfers",
             n_in, n_ignored, n_out);
    $display("bring-ups: %0d completed, %0d failed or aborted; %0d limit writes",
             n_good, n_bad, n_cfg);
    if (n_err == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
